[design/gini_decision_stump_trainer_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the decision stump trainer
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// -----------------------------------------------------------------------------
`ifndef GINI_DECISION_STUMP_TRAINER_ASSERT_SVH
`define GINI_DECISION_STUMP_TRAINER_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define GDST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the next cycle
`define GDST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define GDST_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GDST_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[design/gdst_pkg.sv]
// -----------------------------------------------------------------------------
// gdst_pkg
// Shared types and default constants of the decision stump trainer.
// -----------------------------------------------------------------------------
package gdst_pkg;

   localparam int DEF_MAX_SAMPLES  = 65536;
   localparam int DEF_MAX_FEATURES = 256;
   localparam int DEF_VALUE_BITS   = 32;

   // fixed field widths of the channels
   localparam int VALUE_WIDTH   = 32;
   localparam int FEATURE_WIDTH = 8;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] feature_value;
      logic                          sample_label;
      logic                          first_of_feature;
      logic                          last_of_feature;
      logic                          last_of_set;
   } req_payload_type;

   typedef struct packed {
      logic [FEATURE_WIDTH-1:0]      split_feature;
      logic signed [VALUE_WIDTH-1:0] split_threshold;
      logic                          majority_label;
      logic                          split_found;
   } rsp_payload_type;

   // multiplier status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

[design/gdst_stream_if.sv]
// -----------------------------------------------------------------------------
// gdst_stream_if
// Valid/ready stream channel carrying one payload per beat.
// -----------------------------------------------------------------------------
interface gdst_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/gdst_mul.sv]
// -----------------------------------------------------------------------------
// gdst_mul
// Shared radix-2 shift-add multiplier, one partial product per cycle.
// -----------------------------------------------------------------------------
module gdst_mul import gdst_pkg::*; #(
   parameter int W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [W-1:0]     a_in,
   input  logic [W-1:0]     b_in,
   output mul_status_type   status,
   output logic [2*W-1:0]   product
);
   localparam int IW = $clog2(W + 1);

   logic [W-1:0]  a_ff;
   logic [W-1:0]  hi_ff;
   logic [W-1:0]  lo_ff;
   logic [IW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         a_ff    <= a_in;
         hi_ff   <= '0;
         lo_ff   <= b_in;
         cnt_ff  <= IW'(W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         hi_ff  <= sum[W:1];
         lo_ff  <= {sum[0], lo_ff[W-1:1]};
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == IW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = {hi_ff, lo_ff};

`include "gini_decision_stump_trainer_assert.svh"

   `GDST_ASSERT_NOW(a_start_idle, clock, reset, start, !busy_ff)
   `GDST_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff)
   `GDST_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !busy_ff)

endmodule

[design/gdst_stats.sv]
// -----------------------------------------------------------------------------
// gdst_stats
// Per-pass threshold and saturating sample, positive and left-side counters.
// -----------------------------------------------------------------------------
module gdst_stats import gdst_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         beat,
   input  logic                         clear,
   input  req_payload_type              payload,
   output logic signed [VALUE_BITS-1:0] threshold,
   output logic [CW-1:0]                left_pos,
   output logic [CW-1:0]                left,
   output logic [CW-1:0]                samples,
   output logic [CW-1:0]                positives
);
   logic signed [VALUE_BITS-1:0] thr_ff, thr_in, value;
   logic [CW-1:0] lpos_ff, lpos_in, left_ff, left_in;
   logic [CW-1:0] smp_ff, smp_in, pos_ff, pos_in;
   logic [CW-1:0] lpos_b, left_b, smp_b, pos_b;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      return (c < CW'(MAX_SAMPLES)) ? c + 1'b1 : c;
   endfunction

   assign value = payload.feature_value[VALUE_BITS-1:0];

   always_comb begin
      thr_in = payload.first_of_feature ? value : thr_ff;
      lpos_b = payload.first_of_feature ? '0 : lpos_ff;
      left_b = payload.first_of_feature ? '0 : left_ff;
      smp_b  = payload.first_of_feature ? '0 : smp_ff;
      pos_b  = payload.first_of_feature ? '0 : pos_ff;
      smp_in  = sat_inc(smp_b);
      pos_in  = payload.sample_label ? sat_inc(pos_b) : pos_b;
      left_in = left_b;
      lpos_in = lpos_b;
      if (value <= thr_in) begin
         left_in = sat_inc(left_b);
         if (payload.sample_label) begin
            lpos_in = sat_inc(lpos_b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         thr_ff  <= '0;
         lpos_ff <= '0;
         left_ff <= '0;
         smp_ff  <= '0;
         pos_ff  <= '0;
      end else if (beat) begin
         thr_ff  <= thr_in;
         lpos_ff <= lpos_in;
         left_ff <= left_in;
         smp_ff  <= smp_in;
         pos_ff  <= pos_in;
      end
   end

   assign threshold = thr_ff;
   assign left_pos  = lpos_ff;
   assign left      = left_ff;
   assign samples   = smp_ff;
   assign positives = pos_ff;

`include "gini_decision_stump_trainer_assert.svh"

   `GDST_ASSERT_NOW(a_lpos_le_left, clock, reset, 1'b1, lpos_ff <= left_ff)
   `GDST_ASSERT_NOW(a_left_le_smp, clock, reset, 1'b1, left_ff <= smp_ff)
   `GDST_ASSERT_NOW(a_pos_le_smp, clock, reset, 1'b1, pos_ff <= smp_ff)

endmodule

[design/gini_decision_stump_trainer.sv]
// -----------------------------------------------------------------------------
// gini_decision_stump_trainer
// Streams a feature-major sample set and picks the best Gini decision stump.
// -----------------------------------------------------------------------------
// Samples arrive feature by feature, one beat per sample, and each beat
// updates the pass counters: the first value of a pass is the threshold, and
// the block tallies samples at or below it and the positives among them. A
// beat flagged last_of_feature (or last_of_set) closes the pass and starts
// scoring, during which req_stream.ready is low. Scoring runs one shared
// shift-add multiplier of 2*CW bits (CW = clog2(MAX_SAMPLES+1), 17 by default)
// one partial product per cycle. A pass with an empty left side, or with all
// samples on the left, is skipped; a valid pass multiplies the numerator and
// the denominator, and later valid passes add two cross-multiplications. After
// a beat with last_of_set the result is loaded in state EMIT into an output
// register, where it waits; the next set may start streaming while it
// is still held. Scores 2*l1*l0 / lt^2 are compared exactly by
// cross-multiplication, a strictly lower score wins. The majority label uses
// the counts of the last pass. No clearing pass is needed after reset.
// -----------------------------------------------------------------------------
module gini_decision_stump_trainer import gdst_pkg::*; #(
   parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
   input  logic          clock,
   input  logic          reset,
   gdst_stream_if.sink   req_stream,
   gdst_stream_if.source rsp_stream
);
   // count width, product operand width, feature counter width
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int PW = 2 * CW;
   localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      MUL_NUM,
      MUL_DEN,
      MUL_CROSS_A,
      MUL_CROSS_B,
      FINISH,
      EMIT
   } state_type;

   state_type state_ff;

   req_payload_type req_pl;
   logic            req_beat;

   // pass statistics
   logic signed [VALUE_BITS-1:0] threshold;
   logic [CW-1:0] left_pos, left, samples, positives;
   logic          stats_clear;

   // shared multiplier
   mul_status_type  mul_stat;
   logic            mul_start;
   logic [PW-1:0]   mul_a, mul_b;
   logic [2*PW-1:0] product;

   // scoring and best-so-far
   logic                         last_set_ff;
   logic [PW-1:0]                num_ff, den_ff;
   logic [2*PW-1:0]              cross_a_ff;
   logic [PW-1:0]                best_num_ff, best_den_ff;
   logic [FW-1:0]                best_feat_ff, feat_cnt_ff;
   logic signed [VALUE_BITS-1:0] best_thr_ff;
   logic                         have_best_ff;
   logic                         skip;
   logic                         take_best;
   logic [PW-1:0]                den_now;
   logic [FW-1:0]                feat_next;
   logic                         out_free;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_pl_ff;

   assign req_pl            = req_stream.payload;
   assign req_stream.ready  = (state_ff == IDLE);
   assign req_beat          = req_stream.valid && req_stream.ready;
   assign rsp_stream.valid  = rsp_valid_ff;
   assign rsp_stream.payload = rsp_pl_ff;

   assign out_free    = !rsp_valid_ff || rsp_stream.ready;
   assign stats_clear = (state_ff == EMIT) && out_free;

   gdst_stats #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .VALUE_BITS  (VALUE_BITS),
      .CW          (CW)
   ) u_stats (
      .clock     (clock),
      .reset     (reset),
      .beat      (req_beat),
      .clear     (stats_clear),
      .payload   (req_pl),
      .threshold (threshold),
      .left_pos  (left_pos),
      .left      (left),
      .samples   (samples),
      .positives (positives)
   );

   gdst_mul #(
      .W (PW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .status  (mul_stat),
      .product (product)
   );

   // operand select per multiply step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         MUL_NUM: begin
            mul_a = PW'(left_pos);
            mul_b = PW'(left - left_pos);
         end
         MUL_DEN: begin
            mul_a = PW'(left);
            mul_b = PW'(left);
         end
         MUL_CROSS_A: begin
            mul_a = num_ff;
            mul_b = best_den_ff;
         end
         MUL_CROSS_B: begin
            mul_a = best_num_ff;
            mul_b = den_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // kick the multiplier once on entry to each multiply state
   assign mul_start = ((state_ff == MUL_NUM) || (state_ff == MUL_DEN) ||
                       (state_ff == MUL_CROSS_A) || (state_ff == MUL_CROSS_B)) &&
                      !mul_stat.busy && !mul_stat.done;

   assign skip    = (left == '0) || (left >= samples);
   assign den_now = (state_ff == MUL_DEN) ? product[PW-1:0] : den_ff;

   // first valid pass wins outright, later ones need a strictly lower score
   assign take_best = mul_stat.done &&
                      (((state_ff == MUL_DEN) && !have_best_ff) ||
                       ((state_ff == MUL_CROSS_B) && (cross_a_ff < product)));

   assign feat_next = (feat_cnt_ff == FW'(MAX_FEATURES - 1)) ? '0 : feat_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         last_set_ff  <= 1'b0;
         have_best_ff <= 1'b0;
         feat_cnt_ff  <= '0;
         best_feat_ff <= '0;
         best_thr_ff  <= '0;
         best_num_ff  <= '0;
         best_den_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // EMIT reloads the result register on its own
         if (rsp_valid_ff && rsp_stream.ready && (state_ff != EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (take_best) begin
            have_best_ff <= 1'b1;
            best_num_ff  <= num_ff;
            best_den_ff  <= den_now;
            best_feat_ff <= feat_cnt_ff;
            best_thr_ff  <= threshold;
         end

         case (state_ff)
            IDLE: begin
               if (req_beat && (req_pl.last_of_feature || req_pl.last_of_set)) begin
                  last_set_ff <= req_pl.last_of_set;
                  state_ff    <= CHECK;
               end
            end
            CHECK: begin
               state_ff <= skip ? FINISH : MUL_NUM;
            end
            MUL_NUM: begin
               if (mul_stat.done) begin
                  num_ff   <= {product[PW-2:0], 1'b0};
                  state_ff <= MUL_DEN;
               end
            end
            MUL_DEN: begin
               if (mul_stat.done) begin
                  den_ff   <= product[PW-1:0];
                  state_ff <= have_best_ff ? MUL_CROSS_A : FINISH;
               end
            end
            MUL_CROSS_A: begin
               if (mul_stat.done) begin
                  cross_a_ff <= product;
                  state_ff   <= MUL_CROSS_B;
               end
            end
            MUL_CROSS_B: begin
               if (mul_stat.done) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               feat_cnt_ff <= feat_next;
               state_ff    <= last_set_ff ? EMIT : IDLE;
            end
            EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pl_ff.split_feature   <= have_best_ff ? FEATURE_WIDTH'(best_feat_ff)
                                                            : '0;
                  rsp_pl_ff.split_threshold <= have_best_ff ? VALUE_WIDTH'(best_thr_ff)
                                                            : '0;
                  rsp_pl_ff.majority_label  <= (positives > (samples >> 1));
                  rsp_pl_ff.split_found     <= have_best_ff;
                  // back to the reset state for the next set
                  have_best_ff <= 1'b0;
                  feat_cnt_ff  <= '0;
                  best_feat_ff <= '0;
                  best_thr_ff  <= '0;
                  best_num_ff  <= '0;
                  best_den_ff  <= '0;
                  last_set_ff  <= 1'b0;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

`include "gini_decision_stump_trainer_assert.svh"

   `GDST_ASSERT_NOW(a_ready_mul_idle, clock, reset, req_stream.ready, !mul_stat.busy)
   `GDST_ASSERT_NEXT(a_take_sets_best, clock, reset, take_best, have_best_ff)
   `GDST_ASSERT_NOW(a_emit_clears, clock, reset, $rose(rsp_valid_ff),
                    !have_best_ff && (feat_cnt_ff == '0))

endmodule
